FILE: hw/rtl/cpos_pkg.sv
package cpos_pkg;

  // Coordinate and result widths.
  localparam int COORD_W = 32;
  localparam int DSQ_W   = 64;

  // Operands of the serial multiplier: 33-bit differences and 32-bit
  // fractions both fit a 34-bit signed operand.
  localparam int OP_W  = 34;
  // Accumulator: three 33x33 products summed, or A * 2^32 plus a
  // 33x32 product, all fit 68 signed bits.
  localparam int ACC_W = 68;
  // Divider remainder: den stays below 2^66, so the shifted remainder
  // fits 67 bits.
  localparam int REM_W = 67;
  // Projection parameter t is an unsigned Q0.32 fraction.
  localparam int Q_W   = 32;

  localparam int MAC_CNT_W = $clog2(OP_W);
  localparam int DIV_CNT_W = $clog2(Q_W);

  typedef logic signed [OP_W-1:0]    op_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  // Request to the serial multiply-accumulate unit.
  typedef struct packed {
    logic start;
    logic clr;
    acc_t init;
    op_t  mul_a;
    op_t  mul_b;
  } mac_cmd_t;

  // Request to the serial divider.
  typedef struct packed {
    logic             start;
    logic [REM_W-1:0] num;
    logic [REM_W-1:0] den;
  } div_cmd_t;

endpackage

FILE: hw/rtl/cpos_mac.sv
module cpos_mac import cpos_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mac_cmd_t cmd,
  output logic     busy,
  output logic     done,
  output acc_t     acc
);

  localparam logic [MAC_CNT_W-1:0] LAST_STEP = MAC_CNT_W'(OP_W - 1);

  acc_t                 acc_r;
  acc_t                 mc_r;
  op_t                  y_r;
  logic [MAC_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  acc_t                 addend;

  // The top multiplier bit carries negative weight.
  always_comb begin
    addend = '0;
    if (y_r[0]) begin
      addend = (cnt_r == LAST_STEP) ? -mc_r : mc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      if (cmd.clr) begin
        acc_r <= cmd.init;
      end
      mc_r <= {{(ACC_W-OP_W){cmd.mul_a[OP_W-1]}}, cmd.mul_a};
      y_r  <= cmd.mul_b;
    end else if (busy_r) begin
      acc_r <= acc_r + addend;
      mc_r  <= mc_r <<< 1;
      y_r   <= y_r >>> 1;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign acc  = acc_r;

endmodule

FILE: hw/rtl/cpos_div.sv
module cpos_div import cpos_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  div_cmd_t       cmd,
  output logic           done,
  output logic [Q_W-1:0] quo
);

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(Q_W - 1);

  logic [REM_W-1:0]     rem_r;
  logic [REM_W-1:0]     den_r;
  logic [Q_W-1:0]       quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [REM_W-1:0]     shifted;
  logic                 fits;

  // The remainder stays below den, so its top bit is always clear.
  assign shifted = {rem_r[REM_W-2:0], 1'b0};
  assign fits    = (shifted >= den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r <= cmd.num;
      den_r <= cmd.den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? (shifted - den_r) : shifted;
      quo_r <= {quo_r[Q_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: hw/rtl/closest_point_on_segments.sv
// Nearest point on a set of 3D segments. Each request carries a target
// point, one segment A-B (signed Q16.16) and a last-segment flag; the block
// projects the target onto the segment, clamps the parameter to [0,1], and
// keeps the nearest point of the query (a later segment replaces it only
// when strictly closer). On the last segment one result appears with the
// point and its squared distance (unsigned Q32.32, saturating at all ones),
// and the query state clears. A zero-length segment yields endpoint A.
// One request is worked on at a time. All products go through one
// bit-serial multiply-accumulate unit that retires one multiplier bit per
// cycle: a segment clamped to an endpoint needs nine products, an interior
// one needs twelve products plus a 32-step restoring divider for the
// parameter. A new request is taken while an earlier result still waits on
// the output port.
module closest_point_on_segments import cpos_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_target_x,
  input  logic signed [31:0]   in_target_y,
  input  logic signed [31:0]   in_target_z,
  input  logic signed [31:0]   in_start_x,
  input  logic signed [31:0]   in_start_y,
  input  logic signed [31:0]   in_start_z,
  input  logic signed [31:0]   in_end_x,
  input  logic signed [31:0]   in_end_y,
  input  logic signed [31:0]   in_end_z,
  input  logic                 in_last_segment,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_near_x,
  output logic signed [31:0]   out_near_y,
  output logic signed [31:0]   out_near_z,
  output logic [DSQ_W-1:0]     out_near_dist_sq
);

  // Sequencer states. The four product phases each run three products,
  // one per axis, selected by the axis counter.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NUM  = 4'd1;  // num = AT . AB
  localparam logic [3:0] S_DEN  = 4'd2;  // den = AB . AB
  localparam logic [3:0] S_DEC  = 4'd3;  // pick endpoint or divide
  localparam logic [3:0] S_DIV  = 4'd4;  // t = num * 2^32 / den
  localparam logic [3:0] S_PROJ = 4'd5;  // P = A + AB * t
  localparam logic [3:0] S_DIST = 4'd6;  // |T - P|^2
  localparam logic [3:0] S_UPD  = 4'd7;  // compare against kept point
  localparam logic [3:0] S_EMIT = 4'd8;  // hand result to output register

  localparam logic [1:0] LAST_AXIS = 2'd2;

  logic [3:0]               state_r;
  logic [1:0]               axis_r;
  logic                     wait_r;
  logic                     last_r;

  coord_t                   t_r  [3];
  coord_t                   a_r  [3];
  coord_t                   b_r  [3];
  logic signed [COORD_W:0]  at_r [3];
  logic signed [COORD_W:0]  ab_r [3];
  coord_t                   p_r  [3];

  acc_t                     num_r;
  logic [REM_W-1:0]         den_r;
  logic [Q_W-1:0]           q_r;

  logic [DSQ_W-1:0]         best_dist_r;
  coord_t                   best_x_r;
  coord_t                   best_y_r;
  coord_t                   best_z_r;
  logic                     have_best_r;

  logic                     out_valid_r;
  coord_t                   out_x_r;
  coord_t                   out_y_r;
  coord_t                   out_z_r;
  logic [DSQ_W-1:0]         out_dsq_r;

  mac_cmd_t                 mac_cmd;
  logic                     mac_busy;
  logic                     mac_done;
  acc_t                     mac_acc;
  div_cmd_t                 div_cmd;
  logic                     div_done;
  logic [Q_W-1:0]           div_quo;

  logic                     in_fire;
  logic                     mac_phase;
  logic signed [COORD_W:0]  diff;
  logic                     num_neg;
  logic                     den_zero;
  logic                     num_ge;
  logic [DSQ_W-1:0]         dsq;
  logic                     take;
  logic                     out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign mac_phase = (state_r == S_NUM) || (state_r == S_DEN) ||
                     (state_r == S_PROJ) || (state_r == S_DIST);

  // Target minus candidate point on the current axis.
  assign diff = {t_r[axis_r][COORD_W-1], t_r[axis_r]} -
                {p_r[axis_r][COORD_W-1], p_r[axis_r]};

  // Operand selection for the shared multiply-accumulate unit. The
  // projection preloads A * 2^32 so the upper word of the sum is already
  // A + floor(AB * t / 2^32).
  always_comb begin
    mac_cmd       = '0;
    mac_cmd.start = mac_phase && !wait_r;
    mac_cmd.clr   = (axis_r == 2'd0);
    unique case (state_r)
      S_NUM: begin
        mac_cmd.mul_a = {at_r[axis_r][COORD_W], at_r[axis_r]};
        mac_cmd.mul_b = {ab_r[axis_r][COORD_W], ab_r[axis_r]};
      end
      S_DEN: begin
        mac_cmd.mul_a = {ab_r[axis_r][COORD_W], ab_r[axis_r]};
        mac_cmd.mul_b = {ab_r[axis_r][COORD_W], ab_r[axis_r]};
      end
      S_PROJ: begin
        mac_cmd.clr   = 1'b1;
        mac_cmd.init  = {{(ACC_W-2*COORD_W){a_r[axis_r][COORD_W-1]}},
                         a_r[axis_r], {COORD_W{1'b0}}};
        mac_cmd.mul_a = {ab_r[axis_r][COORD_W], ab_r[axis_r]};
        mac_cmd.mul_b = {{(OP_W-Q_W){1'b0}}, q_r};
      end
      S_DIST: begin
        mac_cmd.mul_a = {diff[COORD_W], diff};
        mac_cmd.mul_b = {diff[COORD_W], diff};
      end
      default: begin
        mac_cmd.start = 1'b0;
      end
    endcase
  end

  // Clamp decision: negative num clamps to A, num at or above a nonzero den to B.
  assign num_neg  = num_r[ACC_W-1];
  assign den_zero = (den_r == '0);
  assign num_ge   = !num_neg && ($unsigned(num_r) >= {1'b0, den_r});

  always_comb begin
    div_cmd       = '0;
    div_cmd.start = (state_r == S_DEC) && !den_zero && !num_neg && !num_ge;
    div_cmd.num   = num_r[REM_W-1:0];
    div_cmd.den   = den_r;
  end

  // Squared distance saturates once it no longer fits 64 bits.
  assign dsq  = (mac_acc[ACC_W-1:DSQ_W] != '0) ? {DSQ_W{1'b1}}
                                                : mac_acc[DSQ_W-1:0];
  assign take = !have_best_r || (dsq < best_dist_r);

  cpos_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (mac_cmd),
    .busy (mac_busy),
    .done (mac_done),
    .acc  (mac_acc)
  );

  cpos_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (div_cmd),
    .done (div_done),
    .quo  (div_quo)
  );

  // Sequencer, kept-point state and output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= '0;
      wait_r      <= 1'b0;
      have_best_r <= 1'b0;
      best_dist_r <= {DSQ_W{1'b1}};
      best_x_r    <= '0;
      best_y_r    <= '0;
      best_z_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (mac_cmd.start) begin
        wait_r <= 1'b1;
      end
      unique case (state_r) inside
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_NUM;
            axis_r  <= '0;
            wait_r  <= 1'b0;
          end
        end
        S_NUM, S_DEN, S_PROJ, S_DIST: begin
          if (mac_done) begin
            wait_r <= 1'b0;
            if (axis_r == LAST_AXIS) begin
              axis_r <= '0;
              unique case (state_r)
                S_NUM:   state_r <= S_DEN;
                S_DEN:   state_r <= S_DEC;
                S_PROJ:  state_r <= S_DIST;
                default: state_r <= S_UPD;
              endcase
            end else begin
              axis_r <= axis_r + 1'b1;
            end
          end
        end
        S_DEC: begin
          state_r <= div_cmd.start ? S_DIV : S_DIST;
          axis_r  <= '0;
          wait_r  <= 1'b0;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_PROJ;
            axis_r  <= '0;
            wait_r  <= 1'b0;
          end
        end
        S_UPD: begin
          if (take) begin
            have_best_r <= 1'b1;
            best_dist_r <= dsq;
            best_x_r    <= p_r[0];
            best_y_r    <= p_r[1];
            best_z_r    <= p_r[2];
          end
          state_r <= last_r ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            have_best_r <= 1'b0;
            best_dist_r <= {DSQ_W{1'b1}};
            best_x_r    <= '0;
            best_y_r    <= '0;
            best_z_r    <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Request capture and datapath results.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      t_r[0] <= in_target_x;
      t_r[1] <= in_target_y;
      t_r[2] <= in_target_z;
      a_r[0] <= in_start_x;
      a_r[1] <= in_start_y;
      a_r[2] <= in_start_z;
      b_r[0] <= in_end_x;
      b_r[1] <= in_end_y;
      b_r[2] <= in_end_z;
      at_r[0] <= {in_target_x[31], in_target_x} - {in_start_x[31], in_start_x};
      at_r[1] <= {in_target_y[31], in_target_y} - {in_start_y[31], in_start_y};
      at_r[2] <= {in_target_z[31], in_target_z} - {in_start_z[31], in_start_z};
      ab_r[0] <= {in_end_x[31], in_end_x} - {in_start_x[31], in_start_x};
      ab_r[1] <= {in_end_y[31], in_end_y} - {in_start_y[31], in_start_y};
      ab_r[2] <= {in_end_z[31], in_end_z} - {in_start_z[31], in_start_z};
      last_r  <= in_last_segment;
    end
    if (mac_done && (axis_r == LAST_AXIS) && (state_r == S_NUM)) begin
      num_r <= mac_acc;
    end
    if (mac_done && (axis_r == LAST_AXIS) && (state_r == S_DEN)) begin
      den_r <= mac_acc[REM_W-1:0];
    end
    if (mac_done && (state_r == S_PROJ)) begin
      p_r[axis_r] <= mac_acc[2*COORD_W-1:COORD_W];
    end
    if ((state_r == S_DEC) && !div_cmd.start) begin
      // Zero-length segments and negative projections land on A.
      if (den_zero || num_neg) begin
        p_r[0] <= a_r[0];
        p_r[1] <= a_r[1];
        p_r[2] <= a_r[2];
      end else begin
        p_r[0] <= b_r[0];
        p_r[1] <= b_r[1];
        p_r[2] <= b_r[2];
      end
    end
    if (div_done) begin
      q_r <= div_quo;
    end
    if ((state_r == S_EMIT) && out_free) begin
      out_x_r   <= best_x_r;
      out_y_r   <= best_y_r;
      out_z_r   <= best_z_r;
      out_dsq_r <= best_dist_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_near_x       = out_x_r;
  assign out_near_y       = out_y_r;
  assign out_near_z       = out_z_r;
  assign out_near_dist_sq = out_dsq_r;

`ifndef SYNTHESIS
  // The divider only runs when the quotient is a proper fraction.
  a_div_fraction: assert property (@(posedge clk) disable iff (!rst_n)
    div_cmd.start |-> (!num_r[ACC_W-1] && ($unsigned(num_r) < {1'b0, den_r})))
    else $error("divider started with num outside [0, den)");

  // Once a candidate is kept, the kept distance never grows in an update.
  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && have_best_r) |=> (best_dist_r <= $past(best_dist_r)))
    else $error("kept squared distance increased");

  // Products only finish inside a product phase.
  a_mac_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (state_r == S_NUM || state_r == S_DEN ||
                  state_r == S_PROJ || state_r == S_DIST))
    else $error("multiplier finished outside a product phase");

  // The multiplier is never restarted while it is still running.
  a_mac_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mac_busy |-> !mac_cmd.start)
    else $error("multiplier restarted while busy");
`endif

endmodule
